[design/rpw_pkg.sv]
// ============================================================================
// Rotated-pole wind rotation package
// Shared widths, beat types, the arctangent table and the Q30 helpers.
// ============================================================================
package rpw_pkg;

    localparam int WIND_WIDTH    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int QW            = 33;
    localparam int ANG_W         = 19;
    localparam int LANES         = 3;
    localparam int PW            = WIND_WIDTH + QW;
    localparam int SW            = WIND_WIDTH + QW + 2;

    localparam logic signed [QW-1:0] Q_ONE = 33'sd1073741824;

    localparam logic [0:0] REG_POLE_LAT = 1'b0;
    localparam logic [0:0] REG_POLE_LON = 1'b1;

    typedef logic signed [ANG_W-1:0] ang_t;

    typedef struct packed {
        logic signed [17:0]           latitude;
        logic signed [19:0]           longitude;
        logic signed [WIND_WIDTH-1:0] east_wind;
        logic signed [WIND_WIDTH-1:0] north_wind;
    } item_t;

    typedef struct packed {
        logic signed [WIND_WIDTH-1:0] rotated_east_wind;
        logic signed [WIND_WIDTH-1:0] rotated_north_wind;
    } result_t;

    typedef struct packed {
        logic signed [WIND_WIDTH-1:0] u;
        logic signed [WIND_WIDTH-1:0] v;
        logic                         lon_neg;
        logic                         lon_pos;
        logic                         lon_zero;
        logic signed [QW-1:0]         sp;
        logic signed [QW-1:0]         cp;
        logic signed [QW-1:0]         sn;
        logic signed [QW-1:0]         cn;
        logic signed [QW-1:0]         p0;
        logic signed [QW-1:0]         p1;
        logic signed [QW-1:0]         p2;
    } ctx_t;

    function automatic logic [31:0] atan_q30(input int unsigned i);
        logic [31:0] r;
        case (i)
            0:  r = 32'd843314856;
            1:  r = 32'd497837829;
            2:  r = 32'd263043836;
            3:  r = 32'd133525158;
            4:  r = 32'd67021686;
            5:  r = 32'd33543515;
            6:  r = 32'd16775850;
            7:  r = 32'd8388437;
            8:  r = 32'd4194282;
            9:  r = 32'd2097149;
            10: r = 32'd1048575;
            11: r = 32'd524287;
            12: r = 32'd262143;
            13: r = 32'd131071;
            14: r = 32'd65535;
            15: r = 32'd32767;
            16: r = 32'd16383;
            17: r = 32'd8191;
            18: r = 32'd4095;
            19: r = 32'd2047;
            20: r = 32'd1023;
            21: r = 32'd511;
            22: r = 32'd255;
            23: r = 32'd127;
            24: r = 32'd63;
            25: r = 32'd31;
            26: r = 32'd15;
            27: r = 32'd8;
            28: r = 32'd4;
            29: r = 32'd2;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] pr;
        pr = a * b;
        return pr[QW+29:30];
    endfunction

    function automatic logic signed [QW-1:0] clamp1(input logic signed [QW+1:0] v);
        logic signed [QW-1:0] r;
        if (v > Q_ONE)
            r = Q_ONE;
        else if (v < -Q_ONE)
            r = -Q_ONE;
        else
            r = v[QW-1:0];
        return r;
    endfunction

    function automatic logic signed [WIND_WIDTH-1:0] sat_wind(input logic signed [SW-1:0] v);
        logic signed [WIND_WIDTH-1:0] hi;
        logic signed [WIND_WIDTH-1:0] lo;
        logic signed [WIND_WIDTH-1:0] r;
        hi = {1'b0, {(WIND_WIDTH-1){1'b1}}};
        lo = {1'b1, {(WIND_WIDTH-1){1'b0}}};
        if (v > hi)
            r = hi;
        else if (v < lo)
            r = lo;
        else
            r = v[WIND_WIDTH-1:0];
        return r;
    endfunction

endpackage

[design/rotated_pole_wind_rotation.sv]
// ============================================================================
// Rotated-pole wind rotation
// Turns one wind pair at one rotated-grid point by the local grid angle.
// ============================================================================
// The block takes one beat per cycle while the result side does not stall and
// returns one result beat for each, through the chain of the 21-stage sine and
// cosine lanes, three 33-stage square-root pipelines and the 32-stage divider;
// every stage moves on together, so a stall on the result side holds the whole
// pipeline and nothing is lost. The user must write the pole position over the
// register port only while the block is idle; the block does not enforce it.
module rotated_pole_wind_rotation
    import rpw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result
);

    logic signed [17:0] pole_latitude_reg;
    logic signed [19:0] pole_longitude_reg;

    logic                 adv;
    logic signed [22:0]   lon_diff;
    logic signed [22:0]   lon_cand;
    logic signed [22:0]   lon_wrap;
    ang_t                 lon_fin;
    ctx_t                 ictx_next;

    logic                 ivld_reg;
    ctx_t                 ictx_reg;
    ang_t                 angle_reg [LANES];

    logic                 cvld;
    logic signed [QW-1:0] sin_q [LANES];
    logic signed [QW-1:0] cos_q [LANES];
    ctx_t                 cctx;

    logic                 t1vld_reg;
    ctx_t                 t1ctx_reg;
    ctx_t                 t1ctx_next;
    logic                 t2vld_reg;
    ctx_t                 t2ctx_reg;
    ctx_t                 t2ctx_next;

    logic                 r1vld;
    logic [30:0]          root1;
    ctx_t                 r1ctx;
    logic                 t3vld_reg;
    ctx_t                 t3ctx_reg;
    ctx_t                 t3ctx_next;
    logic [30:0]          nc;
    logic                 near;

    logic                 dvld;
    logic signed [QW-1:0] cnew;
    ctx_t                 dctx;
    ctx_t                 dctx_mod;

    logic                 r2vld;
    logic [30:0]          root2;
    ctx_t                 r2ctx;
    logic signed [QW-1:0] snew;
    logic                 t4vld_reg;
    ctx_t                 t4ctx_reg;
    ctx_t                 t4ctx_next;
    logic                 t5vld_reg;
    ctx_t                 t5ctx_reg;
    ctx_t                 t5ctx_next;

    logic                 r3vld;
    logic [30:0]          root3;
    ctx_t                 r3ctx;
    logic signed [QW-1:0] sd;
    logic                 pos;
    logic                 t6vld_reg;
    logic signed [PW-1:0] ucd_reg;
    logic signed [PW-1:0] vsd_reg;
    logic signed [PW-1:0] usd_reg;
    logic signed [PW-1:0] vcd_reg;
    logic signed [SW-1:0] sum_e;
    logic signed [SW-1:0] sum_n;

    logic                 result_valid_reg;
    result_t              result_reg;

    // Register port.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_latitude_reg  <= -18'sd90000;
            pole_longitude_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_POLE_LAT: pole_latitude_reg  <= pwdata[17:0];
                REG_POLE_LON: pole_longitude_reg <= pwdata[19:0];
                default:      pole_latitude_reg  <= pole_latitude_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_POLE_LAT: prdata = 32'(pole_latitude_reg);
            REG_POLE_LON: prdata = 32'(pole_longitude_reg);
            default:      prdata = '0;
        endcase
    end

    // The whole pipeline moves whenever the result register can take a beat.
    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;

    // Longitude wrap into the half-open circle.
    always_comb
    begin
        lon_diff = 23'(item.longitude) - 23'(pole_longitude_reg);
        lon_wrap = lon_diff;
        lon_cand = lon_diff;
        for (int k = -3; k <= 3; k++)
        begin
            lon_cand = lon_diff + 23'(k * 360000);
            if (lon_cand >= -23'sd180000 && lon_cand <= 23'sd180000)
            begin
                lon_wrap = lon_cand;
            end
        end
        if (lon_wrap <= -23'sd179999)
        begin
            lon_fin = 19'sd180000;
        end
        else
        begin
            lon_fin = lon_wrap[ANG_W-1:0];
        end
        ictx_next          = '0;
        ictx_next.u        = item.east_wind;
        ictx_next.v        = item.north_wind;
        ictx_next.lon_neg  = lon_fin < 0;
        ictx_next.lon_pos  = lon_fin > 0;
        ictx_next.lon_zero = lon_fin == 0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivld_reg  <= 1'b0;
            t1vld_reg <= 1'b0;
            t2vld_reg <= 1'b0;
            t3vld_reg <= 1'b0;
            t4vld_reg <= 1'b0;
            t5vld_reg <= 1'b0;
            t6vld_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ivld_reg  <= item_valid;
            t1vld_reg <= cvld;
            t2vld_reg <= t1vld_reg;
            t3vld_reg <= r1vld;
            t4vld_reg <= r2vld;
            t5vld_reg <= t4vld_reg;
            t6vld_reg <= r3vld;
            result_valid_reg <= t6vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ictx_reg     <= ictx_next;
            angle_reg[0] <= ang_t'(pole_latitude_reg);
            angle_reg[1] <= ang_t'(item.latitude);
            angle_reg[2] <= lon_fin;
        end
    end

    rpw_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (ivld_reg),
        .angle     (angle_reg),
        .in_ctx    (ictx_reg),
        .out_valid (cvld),
        .sin_q     (sin_q),
        .cos_q     (cos_q),
        .out_ctx   (cctx)
    );

    // Lane 0 is the pole latitude, lane 1 the point latitude, lane 2 the
    // wrapped longitude.
    always_comb
    begin
        t1ctx_next    = cctx;
        t1ctx_next.sp = sin_q[0];
        t1ctx_next.cp = cos_q[0];
        t1ctx_next.sn = sin_q[2];
        t1ctx_next.cn = cos_q[2];
        t1ctx_next.p0 = qmul(cos_q[1], cos_q[2]);
        t1ctx_next.p1 = qmul(sin_q[0], sin_q[1]);
        t1ctx_next.p2 = qmul(cos_q[0], sin_q[1]);

        t2ctx_next    = t1ctx_reg;
        t2ctx_next.p0 = clamp1(-(QW+2)'(t1ctx_reg.p1)
                               - (QW+2)'(qmul(t1ctx_reg.cp, t1ctx_reg.p0)));
        t2ctx_next.p1 = -qmul(t1ctx_reg.sp, t1ctx_reg.p0) + t1ctx_reg.p2;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1ctx_reg <= t1ctx_next;
            t2ctx_reg <= t2ctx_next;
        end
    end

    rpw_comp u_comp_nc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (t2vld_reg),
        .c         (t2ctx_reg.p0),
        .in_ctx    (t2ctx_reg),
        .out_valid (r1vld),
        .root      (root1),
        .out_ctx   (r1ctx)
    );

    // At the pole of the point the cosine of the new latitude falls back to one.
    always_comb
    begin
        near = (r1ctx.p0 >= Q_ONE - 1) || (r1ctx.p0 <= -Q_ONE + 1);
        nc   = near ? 31'd0 : root1;
        if (nc <= 31'd1)
        begin
            nc = Q_ONE[30:0];
        end
        t3ctx_next    = r1ctx;
        t3ctx_next.p2 = $signed(QW'(nc));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t3ctx_reg <= t3ctx_next;
        end
    end

    rpw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (t3vld_reg),
        .num       (t3ctx_reg.p1),
        .den       (t3ctx_reg.p2[30:0]),
        .in_ctx    (t3ctx_reg),
        .out_valid (dvld),
        .quo       (cnew),
        .out_ctx   (dctx)
    );

    always_comb
    begin
        dctx_mod    = dctx;
        dctx_mod.p0 = cnew;
    end

    rpw_comp u_comp_snew (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (dvld),
        .c         (cnew),
        .in_ctx    (dctx_mod),
        .out_valid (r2vld),
        .root      (root2),
        .out_ctx   (r2ctx)
    );

    assign snew = r2ctx.lon_neg ? -$signed(QW'(root2)) : $signed(QW'(root2));

    always_comb
    begin
        t4ctx_next    = r2ctx;
        t4ctx_next.p1 = qmul(r2ctx.sn, snew);
        t4ctx_next.p2 = qmul(r2ctx.cn, r2ctx.p0);

        t5ctx_next    = t4ctx_reg;
        t5ctx_next.p0 = clamp1(-(QW+2)'(qmul(t4ctx_reg.sp, t4ctx_reg.p1))
                               + (QW+2)'(t4ctx_reg.p2));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t4ctx_reg <= t4ctx_next;
            t5ctx_reg <= t5ctx_next;
        end
    end

    rpw_comp u_comp_sd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (t5vld_reg),
        .c         (t5ctx_reg.p0),
        .in_ctx    (t5ctx_reg),
        .out_valid (r3vld),
        .root      (root3),
        .out_ctx   (r3ctx)
    );

    assign pos = (r3ctx.cp == 0) || r3ctx.lon_zero || ((r3ctx.cp > 0) == r3ctx.lon_pos);
    assign sd  = pos ? $signed(QW'(root3)) : -$signed(QW'(root3));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ucd_reg <= r3ctx.u * r3ctx.p0;
            vsd_reg <= r3ctx.v * sd;
            usd_reg <= r3ctx.u * sd;
            vcd_reg <= r3ctx.v * r3ctx.p0;
        end
    end

    assign sum_e = (SW'(ucd_reg) - SW'(vsd_reg) + (SW'(1) <<< 29)) >>> 30;
    assign sum_n = (SW'(usd_reg) + SW'(vcd_reg) + (SW'(1) <<< 29)) >>> 30;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg.rotated_east_wind  <= sat_wind(sum_e);
            result_reg.rotated_north_wind <= sat_wind(sum_n);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[design/rpw_cordic.sv]
// ============================================================================
// Rotated-pole wind rotation: sine and cosine lanes
// Three lanes turn millidegree angles into Q30 sine and cosine through a
// constant-reciprocal radian conversion and a pipelined CORDIC.
// ============================================================================
module rpw_cordic
    import rpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  ang_t                 angle [LANES],
    input  ctx_t                 in_ctx,
    output logic                 out_valid,
    output logic signed [QW-1:0] sin_q [LANES],
    output logic signed [QW-1:0] cos_q [LANES],
    output ctx_t                 out_ctx
);

    localparam int NST = CORDIC_STAGES + 5;
    localparam int XW  = 34;
    localparam logic [30:0] RECIP = 31'd1563749870;
    localparam logic signed [XW-1:0] GAIN = 34'sd652032874;

    logic [NST-1:0] vld_reg;
    ctx_t           ctx_reg [NST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_ctx;
            for (int k = 1; k < NST; k++)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [19:0]      a_ext;
        logic signed [19:0]      fa;
        logic                    fneg;
        logic [16:0]             mag;
        logic [NST-2:0]          neg_reg;
        logic [2:0]              sgn_reg;
        logic [31:0]             n_reg [3];
        logic [30:0]             p_reg [3];
        logic [62:0]             t_reg;
        logic [14:0]             q_reg;
        logic [31:0]             m_reg;
        logic [31:0]             rem;
        logic [14:0]             qf;
        logic [30:0]             zmag;
        logic signed [XW-1:0]    x_reg [CORDIC_STAGES+1];
        logic signed [XW-1:0]    y_reg [CORDIC_STAGES+1];
        logic signed [XW-1:0]    z_reg [CORDIC_STAGES+1];
        logic signed [QW-1:0]    xc;
        logic signed [QW-1:0]    yc;

        always_comb
        begin
            a_ext = 20'(angle[l]);
            fneg  = 1'b0;
            fa    = a_ext;
            if (a_ext > 20'sd90000)
            begin
                fa   = a_ext - 20'sd180000;
                fneg = 1'b1;
            end
            else if (a_ext < -20'sd90000)
            begin
                fa   = a_ext + 20'sd180000;
                fneg = 1'b1;
            end
            mag  = fa[19] ? 17'(-fa) : fa[16:0];
            rem  = n_reg[2] - m_reg;
            qf   = (rem >= 32'd90000) ? q_reg + 15'd1 : q_reg;
            zmag = p_reg[2] + 31'(qf);
            xc   = clamp1((QW+2)'(x_reg[CORDIC_STAGES]));
            yc   = clamp1((QW+2)'(y_reg[CORDIC_STAGES]));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg  <= {neg_reg[NST-3:0], fneg};
                sgn_reg  <= {sgn_reg[1:0], fa[19]};
                n_reg[0] <= 32'(mag) * 32'd29713;
                p_reg[0] <= 31'(mag) * 31'd18740;
                n_reg[1] <= n_reg[0];
                p_reg[1] <= p_reg[0];
                n_reg[2] <= n_reg[1];
                p_reg[2] <= p_reg[1];
                t_reg    <= n_reg[0] * RECIP;
                q_reg    <= t_reg[61:47];
                m_reg    <= 32'(t_reg[61:47]) * 32'd90000;
                x_reg[0] <= GAIN;
                y_reg[0] <= '0;
                z_reg[0] <= sgn_reg[2] ? -$signed({3'b000, zmag})
                                       : $signed({3'b000, zmag});
                sin_q[l] <= neg_reg[NST-2] ? -yc : yc;
                cos_q[l] <= neg_reg[NST-2] ? -xc : xc;
            end
        end

        for (genvar k = 0; k < CORDIC_STAGES; k++)
        begin : g_iter
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!z_reg[k][XW-1])
                    begin
                        x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                        y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                        z_reg[k+1] <= z_reg[k] - $signed({2'b00, atan_q30(k)});
                    end
                    else
                    begin
                        x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                        y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                        z_reg[k+1] <= z_reg[k] + $signed({2'b00, atan_q30(k)});
                    end
                end
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_ctx   = ctx_reg[NST-1];

endmodule

[design/rpw_comp.sv]
// ============================================================================
// Rotated-pole wind rotation: complementary root
// Pipelined floor square root of ONE squared minus c squared, one result bit
// per stage.
// ============================================================================
module rpw_comp
    import rpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [QW-1:0] c,
    input  ctx_t                 in_ctx,
    output logic                 out_valid,
    output logic [30:0]          root,
    output ctx_t                 out_ctx
);

    localparam int NIT = 31;
    localparam int NST = NIT + 2;

    logic [NST-1:0]         vld_reg;
    ctx_t                   ctx_reg [NST];
    logic signed [2*QW-1:0] sq_full;
    logic [60:0]            sq_reg;
    logic [60:0]            v_reg [NIT+1];
    logic [60:0]            res_reg [NIT+1];

    assign sq_full = c * c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_ctx;
            for (int k = 1; k < NST; k++)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
            sq_reg     <= sq_full[60:0];
            v_reg[0]   <= (61'd1 << 60) - sq_reg;
            res_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < NIT; k++)
    begin : g_bit
        localparam logic [60:0] BIT = 61'd1 << (60 - 2*k);
        logic [60:0] trial;

        assign trial = res_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_reg[k] >= trial)
                begin
                    v_reg[k+1]   <= v_reg[k] - trial;
                    res_reg[k+1] <= (res_reg[k] >> 1) + BIT;
                end
                else
                begin
                    v_reg[k+1]   <= v_reg[k];
                    res_reg[k+1] <= res_reg[k] >> 1;
                end
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_ctx   = ctx_reg[NST-1];
    assign root      = res_reg[NIT][30:0];

endmodule

[design/rpw_div.sv]
// ============================================================================
// Rotated-pole wind rotation: Q30 divider
// Pipelined restoring division giving num * ONE / den, truncated toward zero
// and clamped to plus or minus ONE.
// ============================================================================
module rpw_div
    import rpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [QW-1:0] num,
    input  logic [30:0]          den,
    input  ctx_t                 in_ctx,
    output logic                 out_valid,
    output logic signed [QW-1:0] quo,
    output ctx_t                 out_ctx
);

    localparam int NIT = 30;
    localparam int NST = NIT + 2;

    logic [NST-1:0]       vld_reg;
    ctx_t                 ctx_reg [NST];
    logic [QW-1:0]        dmag;
    logic [NIT:0]         neg_reg;
    logic [NIT:0]         sat_reg;
    logic [30:0]          den_reg [NIT+1];
    logic [31:0]          r_reg [NIT+1];
    logic [NIT-1:0]       q_reg [NIT+1];
    logic signed [QW-1:0] mag;

    assign dmag = num[QW-1] ? QW'(-num) : QW'(num);
    assign mag  = sat_reg[NIT] ? Q_ONE : $signed(QW'(q_reg[NIT]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_ctx;
            for (int k = 1; k < NST; k++)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
            neg_reg    <= {neg_reg[NIT-1:0], num[QW-1]};
            sat_reg    <= {sat_reg[NIT-1:0], (dmag >= QW'(den))};
            den_reg[0] <= den;
            r_reg[0]   <= dmag[31:0];
            q_reg[0]   <= '0;
            quo        <= neg_reg[NIT] ? -mag : mag;
        end
    end

    for (genvar k = 0; k < NIT; k++)
    begin : g_bit
        logic [31:0] r2;

        assign r2 = {r_reg[k][30:0], 1'b0};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k+1] <= den_reg[k];
                if (r2 >= 32'(den_reg[k]))
                begin
                    r_reg[k+1] <= r2 - 32'(den_reg[k]);
                    q_reg[k+1] <= {q_reg[k][NIT-2:0], 1'b1};
                end
                else
                begin
                    r_reg[k+1] <= r2;
                    q_reg[k+1] <= {q_reg[k][NIT-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_ctx   = ctx_reg[NST-1];

endmodule

[tb/rotated_pole_wind_rotation_tb.sv]
// ============================================================================
// Rotated-pole wind rotation testbench
// Streams grid points with wind pairs through the block under several pole
// settings. A bit-exact fixed-point model predicts each rotated pair, and
// every result beat is checked in order against it. Both sides idle at
// random, and one long result stall fills the pipeline.
// ============================================================================
`timescale 1ns / 100ps

module rotated_pole_wind_rotation_tb
    import rpw_pkg::*;
();

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint GAIN    = 64'sd652032874;

    class rotation_checker;
        longint pole_lat;
        longint pole_lon;
        result_t pending_winds[$];
        bit failed;

        function new();
            pole_lat = -90000;
            pole_lon = 0;
            failed = 0;
        endfunction

        function longint clamp_one(longint v);
            if (v > ONE_Q30)
                return ONE_Q30;
            if (v < -ONE_Q30)
                return -ONE_Q30;
            return v;
        endfunction

        function longint mul_q30(longint a, longint b);
            return (a * b) >>> 30;
        endfunction

        function longint root_floor(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        function longint complement(longint c);
            return root_floor(longint'(ONE_Q30 * ONE_Q30 - c * c));
        endfunction

        function void sin_cos(longint a, output longint s, output longint c);
            bit neg;
            longint x, y, z, t;
            neg = 0;
            x = GAIN;
            y = 0;
            if (a > 90000)
            begin
                a -= 180000;
                neg = 1;
            end
            else if (a < -90000)
            begin
                a += 180000;
                neg = 1;
            end
            z = (a * PI_Q30) / 180000;
            for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
            begin
                if (z >= 0)
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    x = t;
                    z -= longint'(atan_q30(i));
                end
                else
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    x = t;
                    z += longint'(atan_q30(i));
                end
            end
            x = clamp_one(x);
            y = clamp_one(y);
            s = neg ? -y : y;
            c = neg ? -x : x;
        endfunction

        function longint saturate(longint v);
            longint hi, lo;
            hi = (64'sd1 <<< (WIND_WIDTH - 1)) - 1;
            lo = -(64'sd1 <<< (WIND_WIDTH - 1));
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function result_t rotate_wind(item_t it);
            longint lat, lon, u, v;
            longint sp, cp, sl, cl, sn, cn, z, nc, num, cnew, snew, cd, sd, cc;
            bit pos;
            result_t r;
            lat = longint'(it.latitude);
            lon = longint'(it.longitude) - pole_lon;
            u = longint'(it.east_wind);
            v = longint'(it.north_wind);
            while (lon < -180000)
                lon += 360000;
            while (lon > 180000)
                lon -= 360000;
            if (lon <= -179999)
                lon = 180000;
            sin_cos(pole_lat, sp, cp);
            sin_cos(lat, sl, cl);
            sin_cos(lon, sn, cn);
            cc = mul_q30(cl, cn);
            z = clamp_one(-mul_q30(sp, sl) - mul_q30(cp, cc));
            nc = 0;
            if (!(z >= ONE_Q30 - 1 || z <= -ONE_Q30 + 1))
                nc = complement(z);
            if (nc <= 1)
                nc = ONE_Q30;
            num = -mul_q30(sp, cc) + mul_q30(cp, sl);
            cnew = clamp_one((num * ONE_Q30) / nc);
            snew = complement(cnew);
            if (lon < 0)
                snew = -snew;
            cd = clamp_one(-mul_q30(sp, mul_q30(sn, snew)) + mul_q30(cn, cnew));
            sd = complement(cd);
            pos = (cp == 0) || (lon == 0) || ((cp > 0) == (lon > 0));
            if (!pos)
                sd = -sd;
            r.rotated_east_wind  = WIND_WIDTH'(saturate((u * cd - v * sd
                                                         + (64'sd1 <<< 29)) >>> 30));
            r.rotated_north_wind = WIND_WIDTH'(saturate((u * sd + v * cd
                                                         + (64'sd1 <<< 29)) >>> 30));
            return r;
        endfunction

        function void note_point(item_t it);
            pending_winds = {pending_winds, rotate_wind(it)};
        endfunction

        function void check_wind(result_t got);
            result_t want;
            if (pending_winds.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, got);
                failed = 1;
                return;
            end
            want = pending_winds.pop_front();
            if (got.rotated_east_wind !== want.rotated_east_wind)
            begin
                $display("%0t: rotated_east_wind expected %0d actual %0d", $time,
                         want.rotated_east_wind, got.rotated_east_wind);
                failed = 1;
            end
            if (got.rotated_north_wind !== want.rotated_north_wind)
            begin
                $display("%0t: rotated_north_wind expected %0d actual %0d", $time,
                         want.rotated_north_wind, got.rotated_north_wind);
                failed = 1;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        result_valid;
    logic        result_ready;
    result_t     result;

    rotation_checker checker_h;
    bit quiet;
    bit hold_request;

    rotated_pole_wind_rotation dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic write_reg(input logic [0:0] idx, input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_POLE_LAT)
            checker_h.pole_lat = longint'($signed(value[17:0]));
        else
            checker_h.pole_lon = longint'($signed(value[19:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_point(input item_t it);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        checker_h.note_point(it);
    endtask

    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (checker_h.pending_winds.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    function automatic item_t make_point(int lat, int lon, int u, int v);
        item_t it;
        it.latitude   = 18'(lat);
        it.longitude  = 20'(lon);
        it.east_wind  = WIND_WIDTH'(u);
        it.north_wind = WIND_WIDTH'(v);
        return it;
    endfunction

    function automatic item_t random_point();
        item_t it;
        int sel;
        logic [95:0] raw;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            raw = {$urandom, $urandom, $urandom};
            it  = raw[$bits(item_t)-1:0];
        end
        else
        begin
            it.latitude   = 18'(int'($urandom_range(0, 180000)) - 90000);
            it.longitude  = 20'(int'($urandom_range(0, 720000)) - 360000);
            it.east_wind  = WIND_WIDTH'($urandom);
            it.north_wind = WIND_WIDTH'($urandom);
            if (sel == 1)
                it.latitude = ($urandom_range(0, 1) == 1) ? 18'sd90000 : -18'sd90000;
        end
        return it;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            checker_h.check_wind(result);
    end

    initial
    begin
        int hold;
        result_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                result_ready <= 1'b0;
                for (hold = 0; hold < 400; hold++)
                    @(negedge clk);
            end
            if (quiet || $urandom_range(0, 5) != 0)
                result_ready <= 1'b1;
            else
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1)
                    @(negedge clk);
            end
        end
    end

    initial
    begin
        int lats[6] = '{90000, -90000, 0, 45000, -131072, 131071};
        int lons[7] = '{-360000, 360000, -180000, -179999, 180000, 0, -524288};
        int pole_lats[4] = '{90000, 0, -45000, 131071};
        int pole_lons[4] = '{360000, -360000, 179999, -524288};
        checker_h = new();
        quiet = 0;
        hold_request = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        item = '0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (lats[i])
            send_point(make_point(lats[i], 1000, 32767, -32768));
        foreach (lons[i])
            send_point(make_point(30000, lons[i], -32768, 32767));
        send_point(make_point(-90000, 0, 0, 0));
        send_point(make_point(0, 90000, 256, 256));
        send_point(make_point(60000, -90000, -256, 0));
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase < 4)
            begin
                write_reg(REG_POLE_LAT, pole_lats[phase]);
                write_reg(REG_POLE_LON, pole_lons[phase]);
            end
            else
            begin
                write_reg(REG_POLE_LAT, int'($urandom_range(0, 180000)) - 90000);
                write_reg(REG_POLE_LON, int'($urandom_range(0, 720000)) - 360000);
            end
            quiet = (phase == 5);
            for (int n = 0; n < 200; n++)
            begin
                if (phase == 1 && n == 20)
                    hold_request = 1;
                send_point(random_point());
            end
            drain();
        end

        if (checker_h.failed || checker_h.pending_winds.size() != 0)
            $display("TEST FAILED");
        else
            $display("TEST PASSED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
